FILE: rtl/shd_pkg.sv
// shd_pkg: constants and types for the double SHA-256 header hasher.
// No dependencies.
package shd_pkg;
	localparam logic [31:0] PAD_MARK    = 32'h80000000;
	localparam logic [31:0] HEADER_BITS = 32'h00000280;
	localparam logic [31:0] DIGEST_BITS = 32'h00000100;
	localparam logic [15:0] PROBE_MASK  = 16'hFFFF;
	localparam int unsigned CFG_REGS    = 8;

	typedef logic [31:0] word_t;
	typedef word_t [7:0] hash_t;
	typedef word_t [15:0] block_t;

	localparam hash_t INITIAL_H = '{
		32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
		32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667};

	typedef struct packed {
		logic  start;
		block_t msg;
		hash_t  h_in;
	} cmp_req_t;

	function automatic word_t round_k(input logic [5:0] i);
		word_t k;
		begin
			unique case (i)
				6'd0: k = 32'h428a2f98; 6'd1: k = 32'h71374491; 6'd2: k = 32'hb5c0fbcf;
				6'd3: k = 32'he9b5dba5; 6'd4: k = 32'h3956c25b; 6'd5: k = 32'h59f111f1;
				6'd6: k = 32'h923f82a4; 6'd7: k = 32'hab1c5ed5; 6'd8: k = 32'hd807aa98;
				6'd9: k = 32'h12835b01; 6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
				6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
				6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
				6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
				6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
				6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
				6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
				6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
				6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
				6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
				6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
				6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
				6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
				6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
				6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
				6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
				6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
				6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
				default: k = 32'hc67178f2;
			endcase
			return k;
		end
	endfunction

	function automatic word_t rotr(input word_t x, input int unsigned n);
		return (x >> n) | (x << (32 - n));
	endfunction

	function automatic word_t swap_bytes(input word_t x);
		return {x[7:0], x[15:8], x[23:16], x[31:24]};
	endfunction
endpackage

FILE: rtl/shd_if.sv
// shd_if: valid/ready channel interfaces for the hasher.
// No dependencies.
interface shd_in_if;
	logic        valid;
	logic        ready;
	logic [31:0] merkle_tail;
	logic [31:0] time_word;
	logic [31:0] target_bits;
	logic [31:0] nonce;
	logic        check_probe;
	modport source (output valid, merkle_tail, time_word, target_bits, nonce, check_probe,
		input ready);
	modport sink (input valid, merkle_tail, time_word, target_bits, nonce, check_probe,
		output ready);
endinterface

interface shd_out_if;
	logic        valid;
	logic        ready;
	logic [63:0] digest_bytes_0_7;
	logic [63:0] digest_bytes_8_15;
	logic [63:0] digest_bytes_16_23;
	logic [63:0] digest_bytes_24_31;
	logic        candidate;
	modport source (output valid, digest_bytes_0_7, digest_bytes_8_15, digest_bytes_16_23,
		digest_bytes_24_31, candidate, input ready);
	modport sink (input valid, digest_bytes_0_7, digest_bytes_8_15, digest_bytes_16_23,
		digest_bytes_24_31, candidate, output ready);
endinterface

interface shd_cfg_if;
	logic        valid;
	logic        ready;
	logic [2:0]  index;
	logic [63:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

FILE: rtl/shd_compress.sv
// shd_compress: one SHA-256 compression, one round per cycle, with a
// 16-word rolling message schedule. Depends on shd_pkg.
module shd_compress (
	input  logic             clk,
	input  logic             arst_n,
	input  shd_pkg::cmp_req_t req,
	output logic             done,
	output shd_pkg::hash_t   h_out
);
	import shd_pkg::*;

	block_t      w_q;
	hash_t       st_q;
	hash_t       hin_q;
	logic [5:0]  rnd_q;
	logic        busy_q;
	word_t       s0, s1, w_new, t1, t2;
	word_t       a, b, c, d, e, f, g, hh;

	assign {hh, g, f, e, d, c, b, a} = st_q;

	always_comb begin
		s0 = rotr(w_q[1], 7) ^ rotr(w_q[1], 18) ^ (w_q[1] >> 3);
		s1 = rotr(w_q[14], 17) ^ rotr(w_q[14], 19) ^ (w_q[14] >> 10);
		w_new = w_q[0] + s0 + w_q[9] + s1;
		t1 = hh + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & f) ^ (~e & g))
			+ round_k(rnd_q) + w_q[0];
		t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
		for (int i = 0; i < 8; i++) h_out[i] = hin_q[i] + st_q[i];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
			rnd_q  <= '0;
		end else begin
			done <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				rnd_q  <= '0;
			end else if (busy_q) begin
				rnd_q <= rnd_q + 6'd1;
				if (rnd_q == 6'd63) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			w_q   <= req.msg;
			st_q  <= req.h_in;
			hin_q <= req.h_in;
		end else if (busy_q) begin
			w_q  <= {w_new, w_q[15:1]};
			st_q <= {g, f, e, d + t1, c, b, a, t1 + t2};
		end
	end
endmodule

FILE: rtl/sha256d_header_nonce_hasher_top.sv
// sha256d_header_nonce_hasher_top: double SHA-256 of an 80-byte header.
// Depends on shd_pkg, shd_if and shd_compress.
//
// One nonce per transfer in; one digest transfer out. A single compression
// unit, one round per cycle, runs three 64-round passes in turn (first block,
// second block, outer hash), each started and finished by the sequencer.
// Each pass is a load, the rounds and a done pulse; output valid rises once
// the third pass has finished. The input is not ready while an item is in
// flight or its result waits.
// Configuration writes go to the first-block registers and are to be made
// while the block is idle.
module sha256d_header_nonce_hasher_top (
	input  logic   clk,
	input  logic   arst_n,
	shd_cfg_if.sink cfg,
	shd_in_if.sink  in_ch,
	shd_out_if.source out_ch
);
	import shd_pkg::*;

	typedef enum logic [2:0] {ST_IDLE, ST_P1, ST_P2, ST_P3, ST_OUT} state_t;

	state_t      state_q;
	logic [63:0] blk_q [CFG_REGS];
	block_t      tail_q;      // second block message, captured on transfer
	logic        probe_q;
	hash_t       mid_q;
	cmp_req_t    req;
	logic        done;
	hash_t       h_out;
	block_t      blk1, blk3;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CFG_REGS; i++) blk_q[i] <= '0;
		end else if (cfg.valid) begin
			blk_q[cfg.index] <= cfg.data;
		end
	end

	always_comb begin
		for (int i = 0; i < 8; i++) begin
			blk1[15 - 2 * i] = blk_q[i][63:32];
			blk1[14 - 2 * i] = blk_q[i][31:0];
		end
		blk3 = '0;
		for (int i = 0; i < 8; i++) blk3[i] = h_out[i];
		blk3[8]  = PAD_MARK;
		blk3[15] = DIGEST_BITS;
	end

	// blk1 lists words from index 15 down: flip to word 0 at index 0
	block_t blk1_r;
	always_comb for (int i = 0; i < 16; i++) blk1_r[i] = blk1[15 - i];

	assign in_ch.ready = (state_q == ST_IDLE);

	always_comb begin
		req.start = 1'b0;
		req.msg   = blk1_r;
		req.h_in  = INITIAL_H;
		unique case (state_q)
			ST_IDLE: req.start = in_ch.valid;
			ST_P1: begin
				req.start = done;
				req.msg   = tail_q;
				req.h_in  = h_out;
			end
			ST_P2: begin
				req.start = done;
				req.msg   = blk3;
			end
			default: ;
		endcase
	end

	shd_compress u_cmp (.clk(clk), .arst_n(arst_n), .req(req), .done(done), .h_out(h_out));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			out_ch.valid <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: if (in_ch.valid) state_q <= ST_P1;
				ST_P1:   if (done) state_q <= ST_P2;
				ST_P2:   if (done) state_q <= ST_P3;
				ST_P3: if (done) begin
					state_q      <= ST_OUT;
					out_ch.valid <= 1'b1;
				end
				ST_OUT: if (out_ch.ready) begin
					state_q      <= ST_IDLE;
					out_ch.valid <= 1'b0;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// second block: tail words, swapped nonce, pad mark, zeros, 640-bit length
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_ch.valid) begin
			tail_q  <= {HEADER_BITS, {10{32'h0}}, PAD_MARK, swap_bytes(in_ch.nonce),
				in_ch.target_bits, in_ch.time_word, in_ch.merkle_tail};
			probe_q <= in_ch.check_probe;
		end
		if (state_q == ST_P3 && done) mid_q <= h_out;
	end

	assign out_ch.digest_bytes_0_7   = {mid_q[0], mid_q[1]};
	assign out_ch.digest_bytes_8_15  = {mid_q[2], mid_q[3]};
	assign out_ch.digest_bytes_16_23 = {mid_q[4], mid_q[5]};
	assign out_ch.digest_bytes_24_31 = {mid_q[6], mid_q[7]};
	assign out_ch.candidate = !probe_q || ((mid_q[7][15:0] & PROBE_MASK) == 16'h0);
endmodule
